// ----- src/frc_pkg.sv -----
package frc_pkg;

	localparam logic [7:0] GAP_LIMIT_RESET = 8'd4;
	localparam int unsigned START_W = 8;
	localparam int unsigned LENGTH_W = 9;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = 2;
	localparam int unsigned QUEUE_CNT_W = 3;

	typedef struct packed {
		logic                final_range;
		logic                range_valid;
		logic [LENGTH_W-1:0] range_length;
		logic [START_W-1:0]  range_start;
	} result_t;

endpackage

// ----- src/flagged_register_range_coalescer_top.sv -----
// Flagged register range coalescer. Each input beat carries the wanted flag of
// one register address, in ascending order from 0. The block counts the address
// itself and turns the flagged runs into burst-read ranges. A new run joins the
// pending range when its start minus the pending range's last address is below
// cfg_wr_data as last written (reset value 4). Otherwise the pending range goes
// out as a result beat. The beat with s_tlast set closes the scan: it adds the
// final range, or an empty marker (m_tuser low, length 0) when nothing was
// flagged, with m_tlast set, and the address restarts at 0. The flag and gap
// decision is combinational, so a new beat is taken every cycle while s_tready
// is high. Results pass through a four-entry queue. s_tready drops only while
// fewer than two queue slots are free. A scan end flushing a range yields two
// result beats, so output at one result per cycle with m_tready high sets the rate.
module flagged_register_range_coalescer_top #(
	parameter int unsigned REGISTER_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,   // merge_gap_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [0] wanted, [7:1] zero
	input  logic        s_tlast,       // scan_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,       // [7:0] range_start, [16:8] range_length, [23:17] zero
	output logic        m_tuser,       // range_valid
	output logic        m_tlast        // final_range
);

	localparam int unsigned AW = (REGISTER_COUNT > 2) ? $clog2(REGISTER_COUNT) : 1;
	localparam logic [AW-1:0] ADDR_LAST = AW'(REGISTER_COUNT - 1);

	logic [7:0]    gap_limit_q;
	logic [AW-1:0] scan_address_q;
	logic          inside_run_q;
	logic          range_pending_q;
	logic [AW-1:0] pending_first_q;
	logic [AW-1:0] pending_last_q;

	frc_pkg::result_t                          queue_q [frc_pkg::QUEUE_DEPTH];
	logic [frc_pkg::QUEUE_PTR_W-1:0]           wr_ptr_q;
	logic [frc_pkg::QUEUE_PTR_W-1:0]           rd_ptr_q;
	logic [frc_pkg::QUEUE_CNT_W-1:0]           count_q;

	logic          in_beat;
	logic          out_beat;
	logic          wanted;
	logic [AW-1:0] gap;
	logic [AW+7:0] gap_x;
	logic [AW+7:0] limit_x;
	logic          merge;
	logic          emit_prev;
	logic          inside_run_n;
	logic          range_pending_n;
	logic [AW-1:0] pending_first_n;
	logic [AW-1:0] pending_last_n;
	logic [AW-1:0] scan_address_n;
	logic [AW+8:0] prev_start_x;
	logic [AW+8:0] prev_len_x;
	logic [AW+8:0] fin_start_x;
	logic [AW+8:0] fin_len_x;
	frc_pkg::result_t res_prev;
	frc_pkg::result_t res_final;
	logic [1:0]    n_wr;

	assign wanted   = s_tdata[0];
	assign s_tready = (count_q <= frc_pkg::QUEUE_CNT_W'(frc_pkg::QUEUE_DEPTH - 2));
	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	assign gap     = scan_address_q - pending_last_q;
	assign gap_x   = (AW+8)'(gap);
	assign limit_x = (AW+8)'(gap_limit_q);
	assign merge   = range_pending_q && (scan_address_q > pending_last_q) && (gap_x < limit_x);
	assign emit_prev = wanted && !inside_run_q && range_pending_q && !merge;

	always_comb begin
		range_pending_n = range_pending_q;
		pending_first_n = pending_first_q;
		pending_last_n  = pending_last_q;
		inside_run_n    = wanted;
		if (wanted) begin
			if (!inside_run_q && !merge) begin
				pending_first_n = scan_address_q;
			end
			range_pending_n = 1'b1;
			pending_last_n  = scan_address_q;
		end
	end

	always_comb begin
		prev_start_x = (AW+9)'(pending_first_q);
		prev_len_x   = (AW+9)'(pending_last_q) - (AW+9)'(pending_first_q) + (AW+9)'(1);
		fin_start_x  = (AW+9)'(pending_first_n);
		fin_len_x    = (AW+9)'(pending_last_n) - (AW+9)'(pending_first_n) + (AW+9)'(1);

		res_prev.range_start  = prev_start_x[frc_pkg::START_W-1:0];
		res_prev.range_length = prev_len_x[frc_pkg::LENGTH_W-1:0];
		res_prev.range_valid  = 1'b1;
		res_prev.final_range  = 1'b0;

		res_final.final_range = 1'b1;
		if (range_pending_n) begin
			res_final.range_start  = fin_start_x[frc_pkg::START_W-1:0];
			res_final.range_length = fin_len_x[frc_pkg::LENGTH_W-1:0];
			res_final.range_valid  = 1'b1;
		end else begin
			res_final.range_start  = '0;
			res_final.range_length = '0;
			res_final.range_valid  = 1'b0;
		end

		if (!in_beat) begin
			n_wr = 2'd0;
		end else begin
			n_wr = {1'b0, emit_prev} + {1'b0, s_tlast};
		end

		if (s_tlast || scan_address_q == ADDR_LAST) begin
			scan_address_n = '0;
		end else begin
			scan_address_n = scan_address_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q     <= frc_pkg::GAP_LIMIT_RESET;
			scan_address_q  <= '0;
			inside_run_q    <= 1'b0;
			range_pending_q <= 1'b0;
			pending_first_q <= '0;
			pending_last_q  <= '0;
			wr_ptr_q        <= '0;
			rd_ptr_q        <= '0;
			count_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				gap_limit_q <= cfg_wr_data;
			end
			if (in_beat) begin
				scan_address_q  <= scan_address_n;
				pending_first_q <= pending_first_n;
				pending_last_q  <= pending_last_n;
				if (s_tlast) begin
					inside_run_q    <= 1'b0;
					range_pending_q <= 1'b0;
				end else begin
					inside_run_q    <= inside_run_n && (scan_address_q != ADDR_LAST);
					range_pending_q <= range_pending_n;
				end
			end
			wr_ptr_q <= wr_ptr_q + frc_pkg::QUEUE_PTR_W'(n_wr);
			if (out_beat) begin
				rd_ptr_q <= rd_ptr_q + frc_pkg::QUEUE_PTR_W'(1);
			end
			count_q <= count_q + frc_pkg::QUEUE_CNT_W'(n_wr)
				- frc_pkg::QUEUE_CNT_W'(out_beat);
		end
	end

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			queue_q[wr_ptr_q] <= emit_prev ? res_prev : res_final;
		end
		if (n_wr == 2'd2) begin
			queue_q[wr_ptr_q + frc_pkg::QUEUE_PTR_W'(1)] <= res_final;
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {7'b0, queue_q[rd_ptr_q].range_length, queue_q[rd_ptr_q].range_start};
	assign m_tuser  = queue_q[rd_ptr_q].range_valid;
	assign m_tlast  = queue_q[rd_ptr_q].final_range;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= frc_pkg::QUEUE_CNT_W'(frc_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_tlast |=> scan_address_q == '0 && !range_pending_q && !inside_run_q)
		else $error("scan state not cleared after scan end");

	a_run_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		inside_run_q |-> range_pending_q)
		else $error("run open without pending range");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
		else $error("malformed empty-scan marker");

endmodule
